// ===== src/rcsft_pkg.sv =====
// Shared types and constants for the RCS file tokenizer.
package rcsft_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   typedef enum logic [1:0] {
      KIND_WORD = 2'd0,
      KIND_STR  = 2'd1,
      KIND_SEMI = 2'd2,
      KIND_EOI  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_EOF    = 2'd1,
      ERR_UNTERM = 2'd2
   } err_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      kind_type   kind;
      logic       token_last;
      err_type    error;
   } result_type;

   // One classified input word: one or two results to emit.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } cmd_type;

   localparam result_type NO_RESULT = '{
      has_byte:   1'b0,
      data_byte:  8'h00,
      kind:       KIND_WORD,
      token_last: 1'b0,
      error:      ERR_NONE
   };

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_FF) ||
             (c == CH_LF) || (c == CH_CR);
   endfunction

endpackage

// ===== src/rcsft_front.sv =====
// Front end: accept input words, track lexer mode, build result commands.
module rcsft_front
   import rcsft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       req_eof_allowed,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_WORD   = 2'd1,
      MODE_STR    = 2'd2,
      MODE_STR_AT = 2'd3
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       accept;
   logic       ib_emit;
   result_type ib_res;
   mode_type   ib_mode;
   logic [1:0] count;
   result_type r0, r1;
   logic [7:0] c;
   logic       eoi;

   assign c      = req_in_byte;
   assign eoi    = req_end_of_input;
   assign accept = req_valid && !queue_full;

   // Classify a byte seen between tokens.
   always_comb begin
      ib_emit = 1'b0;
      ib_res  = NO_RESULT;
      ib_mode = MODE_IDLE;
      if (is_space(c)) begin
         ib_emit = 1'b0;
      end else if (c == CH_SEMI) begin
         ib_emit = 1'b1;
         ib_res  = '{has_byte: 1'b1, data_byte: c, kind: KIND_SEMI,
                     token_last: 1'b1, error: ERR_NONE};
      end else if (c == CH_AT) begin
         ib_mode = MODE_STR;
      end else begin
         ib_emit = 1'b1;
         ib_res  = '{has_byte: 1'b1, data_byte: c, kind: KIND_WORD,
                     token_last: 1'b0, error: ERR_NONE};
         ib_mode = MODE_WORD;
      end
   end

   always_comb begin
      count   = 2'd0;
      r0      = NO_RESULT;
      r1      = NO_RESULT;
      mode_in = mode_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (eoi) begin
               count = 2'd1;
               r0    = '{has_byte: 1'b0, data_byte: 8'h00, kind: KIND_EOI,
                         token_last: 1'b1,
                         error: req_eof_allowed ? ERR_NONE : ERR_EOF};
            end else begin
               count   = {1'b0, ib_emit};
               r0      = ib_res;
               mode_in = ib_mode;
            end
         end
         MODE_WORD: begin
            if (eoi) begin
               count   = 2'd1;
               r0      = '{has_byte: 1'b0, data_byte: 8'h00, kind: KIND_WORD,
                           token_last: 1'b1, error: ERR_NONE};
               mode_in = MODE_IDLE;
            end else if (is_space(c) || c == CH_SEMI) begin
               count   = ib_emit ? 2'd2 : 2'd1;
               r0      = '{has_byte: 1'b0, data_byte: 8'h00, kind: KIND_WORD,
                           token_last: 1'b1, error: ERR_NONE};
               r1      = ib_res;
               mode_in = ib_mode;
            end else begin
               count = 2'd1;
               r0    = '{has_byte: 1'b1, data_byte: c, kind: KIND_WORD,
                         token_last: 1'b0, error: ERR_NONE};
            end
         end
         MODE_STR: begin
            if (eoi) begin
               count   = 2'd1;
               r0      = '{has_byte: 1'b0, data_byte: 8'h00, kind: KIND_STR,
                           token_last: 1'b1, error: ERR_UNTERM};
               mode_in = MODE_IDLE;
            end else if (c == CH_AT) begin
               mode_in = MODE_STR_AT;
            end else begin
               count = 2'd1;
               r0    = '{has_byte: 1'b1, data_byte: c, kind: KIND_STR,
                         token_last: 1'b0, error: ERR_NONE};
            end
         end
         MODE_STR_AT: begin
            if (!eoi && c == CH_AT) begin
               count   = 2'd1;
               r0      = '{has_byte: 1'b1, data_byte: CH_AT, kind: KIND_STR,
                           token_last: 1'b0, error: ERR_NONE};
               mode_in = MODE_STR;
            end else begin
               r0 = '{has_byte: 1'b0, data_byte: 8'h00, kind: KIND_STR,
                      token_last: 1'b1, error: ERR_NONE};
               if (eoi) begin
                  count   = 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  count   = ib_emit ? 2'd2 : 2'd1;
                  r1      = ib_res;
                  mode_in = ib_mode;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
   end

   // Pack the first result in the first slot; a single result never uses the second.
   always_comb begin
      cmd.two    = (count == 2'd2);
      cmd.first  = r0;
      cmd.second = r1;
      push       = accept && (count != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ===== src/rcsft_queue.sv =====
// Short command queue between the front end and the output stage.
module rcsft_queue
   import rcsft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == QUEUE_CNT_W'(0));
   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/rcsft_back.sv =====
// Back end: expand queued commands into result words behind an output register.
module rcsft_back
   import rcsft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_token_last,
   output logic [1:0] rsp_error
);

   logic       rsp_valid_ff;
   result_type rsp_ff;
   logic       phase_ff, phase_in;
   logic       load;
   logic       take;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign take = load && !empty;
   assign pop  = take && (phase_ff || !head.two);

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         phase_in = !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            rsp_valid_ff <= !empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= phase_ff ? head.second : head.first;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_byte   = rsp_ff.has_byte;
   assign rsp_data_byte  = rsp_ff.data_byte;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_token_last = rsp_ff.token_last;
   assign rsp_error      = rsp_ff.error;

endmodule

// ===== src/rcs_file_tokenizer.sv =====
// RCS file tokenizer: one input byte per cycle when not stalled, up to two result words per byte.
// The first result word of a byte is written into the command queue, then into the output register.
// Throughput: one input word per cycle while the queue is not full and each byte yields at most one
// result; a two-result byte uses the single output register twice, absorbed by a 4-entry queue.
// Reset (synchronous): lexer mode returns to between-tokens, queue and output register empty.
module rcs_file_tokenizer
   import rcsft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       req_eof_allowed,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_token_last,
   output logic [1:0] rsp_error
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head;
   logic    empty;
   logic    full;

   assign req_stall = full;

   rcsft_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .req_eof_allowed  (req_eof_allowed),
      .queue_full       (full),
      .push             (push),
      .cmd              (push_cmd)
   );

   rcsft_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   rcsft_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_kind       (rsp_kind),
      .rsp_token_last (rsp_token_last),
      .rsp_error      (rsp_error)
   );

endmodule

// ===== dv/rcs_file_tokenizer_check.sv =====
// Checker for the RCS file tokenizer: predicts the token stream and compares it word by word.
`timescale 1ns / 100ps
module rcs_file_tokenizer_check
   import rcsft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       req_eof_allowed,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_has_byte,
   input  logic [7:0] rsp_data_byte,
   input  logic [1:0] rsp_kind,
   input  logic       rsp_token_last,
   input  logic [1:0] rsp_error,
   output int         fail_count,
   output int         pending
);

   typedef enum logic [1:0] {
      LEX_IDLE,
      LEX_WORD,
      LEX_STR,
      LEX_STR_AT
   } lex_mode_type;

   lex_mode_type lex_mode;
   result_type   token_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
      lex_mode   = LEX_IDLE;
   end

   function automatic logic blank_byte(input logic [7:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_FF, CH_LF, CH_CR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic emit(input logic has, input logic [7:0] data, input kind_type kind,
                       input logic last, input err_type err);
      result_type r;
      r.has_byte   = has;
      r.data_byte  = data;
      r.kind       = kind;
      r.token_last = last;
      r.error      = err;
      token_q.push_back(r);
   endtask

   task automatic lex_between(input logic [7:0] c);
      if (blank_byte(c)) begin
         lex_mode = LEX_IDLE;
      end else if (c == CH_SEMI) begin
         emit(1'b1, c, KIND_SEMI, 1'b1, ERR_NONE);
      end else if (c == CH_AT) begin
         lex_mode = LEX_STR;
      end else begin
         emit(1'b1, c, KIND_WORD, 1'b0, ERR_NONE);
         lex_mode = LEX_WORD;
      end
   endtask

   task automatic lex_input(input logic [7:0] c, input logic eoi, input logic allow);
      case (lex_mode)
         LEX_IDLE: begin
            if (eoi)
               emit(1'b0, 8'h00, KIND_EOI, 1'b1, allow ? ERR_NONE : ERR_EOF);
            else
               lex_between(c);
         end
         LEX_WORD: begin
            if (eoi) begin
               emit(1'b0, 8'h00, KIND_WORD, 1'b1, ERR_NONE);
               lex_mode = LEX_IDLE;
            end else if (blank_byte(c) || c == CH_SEMI) begin
               emit(1'b0, 8'h00, KIND_WORD, 1'b1, ERR_NONE);
               lex_mode = LEX_IDLE;
               lex_between(c);
            end else begin
               emit(1'b1, c, KIND_WORD, 1'b0, ERR_NONE);
            end
         end
         LEX_STR: begin
            if (eoi) begin
               emit(1'b0, 8'h00, KIND_STR, 1'b1, ERR_UNTERM);
               lex_mode = LEX_IDLE;
            end else if (c == CH_AT) begin
               lex_mode = LEX_STR_AT;
            end else begin
               emit(1'b1, c, KIND_STR, 1'b0, ERR_NONE);
            end
         end
         default: begin
            if (!eoi && c == CH_AT) begin
               emit(1'b1, CH_AT, KIND_STR, 1'b0, ERR_NONE);
               lex_mode = LEX_STR;
            end else begin
               emit(1'b0, 8'h00, KIND_STR, 1'b1, ERR_NONE);
               lex_mode = LEX_IDLE;
               if (!eoi)
                  lex_between(c);
            end
         end
      endcase
   endtask

   task automatic flag_field(input string field, input logic [7:0] expv,
                             input logic [7:0] actv);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expv, actv);
      fail_count++;
   endtask

   task automatic check_word();
      result_type r;
      if (token_q.size() == 0) begin
         $display("%0t: unexpected result word, data %h kind %0d", $time, rsp_data_byte,
                  rsp_kind);
         fail_count++;
      end else begin
         r = token_q.pop_front();
         if (rsp_has_byte !== r.has_byte)
            flag_field("has_byte", 8'(r.has_byte), 8'(rsp_has_byte));
         if (rsp_data_byte !== r.data_byte)
            flag_field("data_byte", r.data_byte, rsp_data_byte);
         if (rsp_kind !== r.kind)
            flag_field("kind", 8'(r.kind), 8'(rsp_kind));
         if (rsp_token_last !== r.token_last)
            flag_field("token_last", 8'(r.token_last), 8'(rsp_token_last));
         if (rsp_error !== r.error)
            flag_field("error", 8'(r.error), 8'(rsp_error));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lex_mode = LEX_IDLE;
         token_q.delete();
      end else begin
         if (req_valid && !req_stall)
            lex_input(req_in_byte, req_end_of_input, req_eof_allowed);
         if (rsp_valid && !rsp_stall)
            check_word();
      end
      pending = token_q.size();
   end

endmodule

// ===== dv/rcs_file_tokenizer_test.sv =====
// Testbench top for the RCS file tokenizer: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps
module rcs_file_tokenizer_test
   import rcsft_pkg::*;
();

   localparam int ITEM_COUNT   = 1850;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_OFF     = 300;
   localparam int DRAIN_CYCLES = 20;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte      = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       req_eof_allowed  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic       rsp_has_byte;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_kind;
   logic       rsp_token_last;
   logic [1:0] rsp_error;

   int fail_count;
   int pending;
   int sent        = 0;
   int burst_left  = 0;
   int idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   rcs_file_tokenizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .req_eof_allowed  (req_eof_allowed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_kind         (rsp_kind),
      .rsp_token_last   (rsp_token_last),
      .rsp_error        (rsp_error)
   );

   rcs_file_tokenizer_check token_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .req_eof_allowed  (req_eof_allowed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_kind         (rsp_kind),
      .rsp_token_last   (rsp_token_last),
      .rsp_error        (rsp_error),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   function automatic logic is_delim(input logic [7:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_FF, CH_LF, CH_CR, CH_SEMI: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 4))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_FF;
         3: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] word_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (is_delim(c))
         c = c | 8'h80;
      return c;
   endfunction

   function automatic logic [7:0] string_char();
      case ($urandom_range(0, 9))
         0: return blank_char();
         1: return CH_SEMI;
         2: return CH_AT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eoi, input logic allow);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_end_of_input <= eoi;
      req_eof_allowed  <= allow;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent++;
   endtask

   task automatic send_text(input logic [7:0] b);
      send_item(b, 1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_end(input logic allow);
      send_item(8'($urandom_range(0, 255)), 1'b1, allow);
   endtask

   task automatic send_word_token();
      int len;
      logic [7:0] c;
      len = $urandom_range(1, 6);
      c = word_char();
      if (c == CH_AT)
         c = c | 8'h80;
      send_text(c);
      repeat (len - 1) send_text(word_char());
      case ($urandom_range(0, 9))
         0, 1: send_text(CH_SEMI);
         2: ;
         default: send_text(blank_char());
      endcase
   endtask

   task automatic send_string_token();
      int len;
      logic [7:0] c;
      len = $urandom_range(0, 6);
      send_text(CH_AT);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 39) == 0) begin
            send_end(1'($urandom_range(0, 1)));
            return;
         end
         c = string_char();
         send_text(c);
         if (c == CH_AT)
            send_text(CH_AT);
      end
      send_text(CH_AT);
      if ($urandom_range(0, 1) == 0)
         send_text(blank_char());
   endtask

   initial begin : receiver
      int stall_mode;
      int phase;
      stall_mode = 0;
      phase      = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (phase == 300 || phase == 1500) begin
            repeat (HOLD_OFF) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         if (phase % 64 == 0)
            stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (phase % 3 == 0);
         endcase
         phase++;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int r;
      int len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_text(CH_SPACE);
      send_text(CH_TAB);
      send_text(CH_SEMI);
      send_text(8'h78);
      send_text(8'hFF);
      send_text(CH_AT);
      send_text(CH_SEMI);
      send_text(CH_AT);
      send_text(CH_AT);
      send_text(8'h41);
      send_text(CH_LF);
      send_text(CH_AT);
      send_text(8'h00);
      send_text(CH_AT);
      send_text(CH_AT);
      send_text(CH_AT);
      send_text(CH_SEMI);
      send_end(1'b1);
      send_end(1'b0);
      send_text(8'h77);
      send_end(1'b1);
      send_end(1'b1);
      send_text(CH_AT);
      send_text(CH_CR);
      send_text(CH_AT);
      send_end(1'b0);
      send_text(CH_AT);
      send_text(CH_FF);
      send_end(1'b1);

      while (sent < ITEM_COUNT) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            send_word_token();
         end else if (r < 65) begin
            send_string_token();
         end else if (r < 75) begin
            send_text(CH_SEMI);
         end else if (r < 85) begin
            len = $urandom_range(1, 3);
            repeat (len) send_text(blank_char());
         end else if (r < 95) begin
            send_text(8'($urandom_range(0, 255)));
         end else begin
            send_end(1'($urandom_range(0, 1)));
         end
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
